/* hw/rtl/sfp_pkg.sv */
// Shared types and constants for the SYN fingerprint parser.
package sfp_pkg;

	localparam int MAX_PKT_BYTES = 256;

	// Byte positions; wide enough for a position plus one option length byte
	localparam int POS_W  = $clog2(MAX_PKT_BYTES + 256);
	localparam int WIDE_W = POS_W + 1;
	// Next extension-header start: start + (len + 1) * 8
	localparam int NX_W   = $clog2(MAX_PKT_BYTES + 2049);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;
	localparam logic [3:0] IHL_MIN  = 4'd5;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] OPT_NOP    = 8'd1;
	localparam logic [7:0] OPT_MSS    = 8'd2;
	localparam logic [7:0] OPT_WSCALE = 8'd3;

	localparam int IPV4_ECN_POS = 1;
	localparam int IPV4_TTL_POS = 8;
	localparam int IPV6_TC_POS  = 1;
	localparam int IPV6_NH_POS  = 6;
	localparam int IPV6_HL_POS  = 7;
	localparam int IPV6_HDR_LEN = 40;

	localparam int TCP_FLAGS_OFS = 13;
	localparam int TCP_DOFF_OFS  = 12;
	localparam int TCP_WIN_HI    = 14;
	localparam int TCP_WIN_LO    = 15;
	localparam int TCP_FIXED_LEN = 20;

	localparam logic REC_OPTION  = 1'b0;
	localparam logic REC_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0,
		ST_IPV4    = 2'd1,
		ST_IPV6    = 2'd2,
		ST_INVALID = 2'd3
	} sfp_status_t;

	typedef struct packed {
		logic        record_type;
		logic [1:0]  ip_version_code;
		logic [7:0]  hop_limit;
		logic [1:0]  ip_ecn;
		logic [15:0] tcp_window;
		logic [1:0]  tcp_ecn;
		logic [15:0] mss_value;
		logic        mss_found;
		logic [7:0]  wscale_value;
		logic        wscale_found;
		logic [7:0]  option_kind;
		logic        last_of_run;
	} sfp_rec_t;

	// Up to two records per byte: option record first, then summary
	typedef struct packed {
		logic     opt_vld;
		logic     sum_vld;
		sfp_rec_t opt_rec;
		sfp_rec_t sum_rec;
	} sfp_push_t;

endpackage

/* hw/rtl/sfp_parse.sv */
// Per-byte header parser: packet state, option walk and record generation.
module sfp_parse import sfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] byte_in,
	input  logic       eop_in,
	output sfp_push_t  push
);

	logic [POS_W-1:0] pos_q, pos_d;
	sfp_status_t      status_q, status_d;
	logic [POS_W-1:0] tcp_start_q, tcp_start_d;
	logic [POS_W-1:0] hdr_end_q, hdr_end_d;
	logic [7:0]       chain_nh_q, chain_nh_d;
	logic [POS_W-1:0] ext_start_q, ext_start_d;
	logic [7:0]       hop_q, hop_d;
	logic [1:0]       ip_ecn_q, ip_ecn_d;
	logic [15:0]      win_q, win_d;
	logic [1:0]       tcp_ecn_q, tcp_ecn_d;
	logic [POS_W-1:0] cursor_q, cursor_d;
	logic [7:0]       pend_kind_q, pend_kind_d;
	logic [15:0]      mss_q, mss_d;
	logic [7:0]       wscale_q, wscale_d;
	logic [1:0]       found_q, found_d;
	logic             len_wait_q, len_wait_d;
	logic             mss_claim_q, mss_claim_d;
	logic             ws_claim_q, ws_claim_d;
	logic [POS_W-1:0] mss_at_q, mss_at_d;
	logic [POS_W-1:0] ws_at_q, ws_at_d;

	logic [WIDE_W-1:0] p_w, t_w, hdr_end_w, ext_w, mss_at_w, ws_at_w;
	logic [NX_W-1:0]   nx;
	logic              stop;
	logic              ok;

	assign p_w       = WIDE_W'(pos_q);
	assign t_w       = WIDE_W'(tcp_start_q);
	assign hdr_end_w = WIDE_W'(hdr_end_q);
	assign ext_w     = WIDE_W'(ext_start_q);
	assign mss_at_w  = WIDE_W'(mss_at_q);
	assign ws_at_w   = WIDE_W'(ws_at_q);
	assign nx        = NX_W'(ext_start_q) + NX_W'({byte_in, 3'b000}) + NX_W'(8);

	always_comb begin
		pos_d       = pos_q;
		status_d    = status_q;
		tcp_start_d = tcp_start_q;
		hdr_end_d   = hdr_end_q;
		chain_nh_d  = chain_nh_q;
		ext_start_d = ext_start_q;
		hop_d       = hop_q;
		ip_ecn_d    = ip_ecn_q;
		win_d       = win_q;
		tcp_ecn_d   = tcp_ecn_q;
		cursor_d    = cursor_q;
		pend_kind_d = pend_kind_q;
		mss_d       = mss_q;
		wscale_d    = wscale_q;
		found_d     = found_q;
		len_wait_d  = len_wait_q;
		mss_claim_d = mss_claim_q;
		ws_claim_d  = ws_claim_q;
		mss_at_d    = mss_at_q;
		ws_at_d     = ws_at_q;
		stop        = 1'b0;
		ok          = 1'b0;
		push        = '0;

		if (go) begin
			if (pos_q < POS_W'(MAX_PKT_BYTES)) begin
				pos_d = pos_q + POS_W'(1);
				if (status_q != ST_INVALID) begin
					if (pos_q == '0) begin
						if (byte_in[7:4] == VER_IPV4) begin
							if (byte_in[3:0] < IHL_MIN) begin
								status_d = ST_INVALID;
							end else begin
								status_d    = ST_IPV4;
								tcp_start_d = POS_W'({byte_in[3:0], 2'b00});
								cursor_d    = POS_W'({byte_in[3:0], 2'b00}) +
									POS_W'(TCP_FIXED_LEN);
							end
						end else if (byte_in[7:4] == VER_IPV6) begin
							status_d = ST_IPV6;
						end else begin
							status_d = ST_INVALID;
						end
					end else begin
						if (status_q == ST_IPV4) begin
							if (pos_q == POS_W'(IPV4_ECN_POS)) ip_ecn_d = byte_in[1:0];
							if (pos_q == POS_W'(IPV4_TTL_POS)) hop_d = byte_in;
						end else if (status_q == ST_IPV6) begin
							if (pos_q == POS_W'(IPV6_TC_POS)) ip_ecn_d = byte_in[5:4];
							if (pos_q == POS_W'(IPV6_NH_POS)) begin
								if (byte_in == PROTO_TCP) begin
									tcp_start_d = POS_W'(IPV6_HDR_LEN);
									cursor_d    = POS_W'(IPV6_HDR_LEN + TCP_FIXED_LEN);
								end else begin
									ext_start_d = POS_W'(IPV6_HDR_LEN);
								end
							end
							if (pos_q == POS_W'(IPV6_HL_POS)) hop_d = byte_in;
							if (ext_start_q != '0 && pos_q == ext_start_q)
								chain_nh_d = byte_in;
							if (ext_start_q != '0 && p_w == ext_w + WIDE_W'(1)) begin
								ext_start_d = '0;
								if (nx >= NX_W'(MAX_PKT_BYTES)) begin
									status_d = ST_INVALID;
									stop     = 1'b1;
								end else if (chain_nh_q == PROTO_TCP) begin
									tcp_start_d = nx[POS_W-1:0];
									cursor_d    = nx[POS_W-1:0] + POS_W'(TCP_FIXED_LEN);
								end else begin
									ext_start_d = nx[POS_W-1:0];
								end
							end
						end

						// A header located on this byte always starts later, so the
						// registered start is the right one here
						if (!stop && tcp_start_q != '0 && pos_q >= tcp_start_q) begin
							if (p_w == t_w + WIDE_W'(TCP_DOFF_OFS))
								hdr_end_d = tcp_start_q + POS_W'({byte_in[7:4], 2'b00});
							if (p_w == t_w + WIDE_W'(TCP_FLAGS_OFS)) tcp_ecn_d = byte_in[7:6];
							if (p_w == t_w + WIDE_W'(TCP_WIN_HI)) win_d = {byte_in, 8'h00};
							if (p_w == t_w + WIDE_W'(TCP_WIN_LO)) win_d = win_q | 16'(byte_in);

							if (p_w >= t_w + WIDE_W'(TCP_FIXED_LEN) && p_w < hdr_end_w) begin
								if (len_wait_q) begin
									len_wait_d = 1'b0;
									if (byte_in != 8'h00) begin
										if (pend_kind_q == OPT_MSS && !mss_claim_q) begin
											mss_claim_d = 1'b1;
											mss_at_d    = cursor_q;
										end
										if (pend_kind_q == OPT_WSCALE && !ws_claim_q) begin
											ws_claim_d = 1'b1;
											ws_at_d    = cursor_q;
										end
										cursor_d = cursor_q + POS_W'(byte_in);
									end else begin
										cursor_d = pos_q;
									end
								end
								if (pos_q == cursor_d) begin
									push.opt_vld                 = 1'b1;
									push.opt_rec.record_type     = REC_OPTION;
									push.opt_rec.ip_version_code = 2'(status_q);
									push.opt_rec.option_kind     = byte_in;
									if (byte_in > OPT_NOP) begin
										len_wait_d  = 1'b1;
										pend_kind_d = byte_in;
									end else begin
										cursor_d = pos_q + POS_W'(1);
									end
								end
								if (mss_claim_q && p_w == mss_at_w + WIDE_W'(2))
									mss_d = {byte_in, 8'h00};
								if (mss_claim_q && p_w == mss_at_w + WIDE_W'(3)) begin
									mss_d      = mss_q | 16'(byte_in);
									found_d[0] = 1'b1;
								end
								if (ws_claim_q && p_w == ws_at_w + WIDE_W'(2)) begin
									wscale_d   = byte_in;
									found_d[1] = 1'b1;
								end
							end
						end
					end
				end
			end

			if (eop_in) begin
				ok = (status_d == ST_IPV4 || status_d == ST_IPV6) && tcp_start_d != '0 &&
					WIDE_W'(pos_d) >= WIDE_W'(tcp_start_d) + WIDE_W'(TCP_FIXED_LEN);
				push.sum_vld                 = 1'b1;
				push.sum_rec.record_type     = REC_SUMMARY;
				push.sum_rec.last_of_run     = 1'b1;
				if (ok) begin
					push.sum_rec.ip_version_code = 2'(status_d);
					push.sum_rec.hop_limit       = hop_d;
					push.sum_rec.ip_ecn          = ip_ecn_d;
					push.sum_rec.tcp_window      = win_d;
					push.sum_rec.tcp_ecn         = tcp_ecn_d;
					push.sum_rec.mss_value       = found_d[0] ? mss_d : 16'h0000;
					push.sum_rec.mss_found       = found_d[0];
					push.sum_rec.wscale_value    = found_d[1] ? wscale_d : 8'h00;
					push.sum_rec.wscale_found    = found_d[1];
				end
				// packet closed: back to the idle values
				pos_d       = '0;
				status_d    = ST_UNKNOWN;
				tcp_start_d = '0;
				hdr_end_d   = '1;
				chain_nh_d  = '0;
				ext_start_d = '0;
				hop_d       = '0;
				ip_ecn_d    = '0;
				win_d       = '0;
				tcp_ecn_d   = '0;
				cursor_d    = '0;
				pend_kind_d = '0;
				mss_d       = '0;
				wscale_d    = '0;
				found_d     = '0;
				len_wait_d  = 1'b0;
				mss_claim_d = 1'b0;
				ws_claim_d  = 1'b0;
				mss_at_d    = '0;
				ws_at_d     = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			status_q    <= ST_UNKNOWN;
			tcp_start_q <= '0;
			hdr_end_q   <= '1;
			chain_nh_q  <= '0;
			ext_start_q <= '0;
			hop_q       <= '0;
			ip_ecn_q    <= '0;
			win_q       <= '0;
			tcp_ecn_q   <= '0;
			cursor_q    <= '0;
			pend_kind_q <= '0;
			mss_q       <= '0;
			wscale_q    <= '0;
			found_q     <= '0;
			len_wait_q  <= 1'b0;
			mss_claim_q <= 1'b0;
			ws_claim_q  <= 1'b0;
			mss_at_q    <= '0;
			ws_at_q     <= '0;
		end else begin
			pos_q       <= pos_d;
			status_q    <= status_d;
			tcp_start_q <= tcp_start_d;
			hdr_end_q   <= hdr_end_d;
			chain_nh_q  <= chain_nh_d;
			ext_start_q <= ext_start_d;
			hop_q       <= hop_d;
			ip_ecn_q    <= ip_ecn_d;
			win_q       <= win_d;
			tcp_ecn_q   <= tcp_ecn_d;
			cursor_q    <= cursor_d;
			pend_kind_q <= pend_kind_d;
			mss_q       <= mss_d;
			wscale_q    <= wscale_d;
			found_q     <= found_d;
			len_wait_q  <= len_wait_d;
			mss_claim_q <= mss_claim_d;
			ws_claim_q  <= ws_claim_d;
			mss_at_q    <= mss_at_d;
			ws_at_q     <= ws_at_d;
		end
	end

endmodule

/* hw/rtl/sfp_fifo.sv */
// Result queue: takes up to two records per cycle, hands out one per transfer.
module sfp_fifo import sfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sfp_push_t push,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output sfp_rec_t  head
);

	sfp_rec_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic [FIFO_CW-1:0] n_push;
	logic               pop;

	assign n_push    = FIFO_CW'(push.opt_vld) + FIFO_CW'(push.sum_vld);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rptr_q];
	// room for a byte that emits both record kinds
	assign room      = count_q <= FIFO_CW'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.opt_vld) mem_q[wptr_q] <= push.opt_rec;
		if (push.sum_vld) begin
			if (push.opt_vld) mem_q[wptr_q + FIFO_AW'(1)] <= push.sum_rec;
			else mem_q[wptr_q] <= push.sum_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + FIFO_AW'(n_push);
			if (pop) rptr_q <= rptr_q + FIFO_AW'(1);
			count_q <= count_q + n_push - FIFO_CW'(pop);
		end
	end

endmodule

/* hw/rtl/syn_fingerprint_parser_top.sv */
// SYN fingerprint parser top level: input register, parser and result queue.
//
// Input channel (in_valid/in_ready) carries one packet byte per transfer,
// starting at the first IP header byte; end_of_packet flags the last byte.
// Output channel (out_valid/out_ready) carries records: one option record
// for each TCP option kind walked, and one summary record (last_of_run = 1)
// that closes each packet. A byte yields zero, one or two records.
// A byte taken into the input register is parsed once the queue has room;
// its records enter the queue as it is parsed, option record first.
// Throughput: one byte per cycle while the queue has room. Each byte is
// parsed by the logic between the input register and the four-entry queue.
// The parser only takes a byte while the queue can still absorb two
// records, so when the receiver stalls the queue fills and in_ready drops;
// no record is lost or dropped.
// Reset clears the packet state, the input register and the queue; the
// first byte after reset is taken as the start of a packet.
module syn_fingerprint_parser_top import sfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pkt_byte,
	input  logic        end_of_packet,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        record_type,
	output logic [1:0]  ip_version_code,
	output logic [7:0]  hop_limit,
	output logic [1:0]  ip_ecn,
	output logic [15:0] tcp_window,
	output logic [1:0]  tcp_ecn,
	output logic [15:0] mss_value,
	output logic        mss_found,
	output logic [7:0]  wscale_value,
	output logic        wscale_found,
	output logic [7:0]  option_kind,
	output logic        last_of_run
);

	logic       valid_s1;
	logic [7:0] pkt_byte_s1;
	logic       eop_s1;
	logic       room;
	logic       go;
	sfp_push_t  push;
	sfp_rec_t   head;

	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pkt_byte_s1 <= pkt_byte;
			eop_s1      <= end_of_packet;
		end
	end

	sfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.byte_in (pkt_byte_s1),
		.eop_in  (eop_s1),
		.push    (push)
	);

	sfp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign record_type     = head.record_type;
	assign ip_version_code = head.ip_version_code;
	assign hop_limit       = head.hop_limit;
	assign ip_ecn          = head.ip_ecn;
	assign tcp_window      = head.tcp_window;
	assign tcp_ecn         = head.tcp_ecn;
	assign mss_value       = head.mss_value;
	assign mss_found       = head.mss_found;
	assign wscale_value    = head.wscale_value;
	assign wscale_found    = head.wscale_found;
	assign option_kind     = head.option_kind;
	assign last_of_run     = head.last_of_run;

endmodule

/* hw/rtl/sfp_checker.sv */
// Port-level checks for the SYN fingerprint parser, bound to the top level.
module sfp_checker import sfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  pkt_byte,
	input logic        end_of_packet,
	input logic        out_valid,
	input logic        out_ready,
	input logic        record_type,
	input logic [1:0]  ip_version_code,
	input logic [7:0]  hop_limit,
	input logic [1:0]  ip_ecn,
	input logic [15:0] tcp_window,
	input logic [1:0]  tcp_ecn,
	input logic [15:0] mss_value,
	input logic        mss_found,
	input logic [7:0]  wscale_value,
	input logic        wscale_found,
	input logic [7:0]  option_kind,
	input logic        last_of_run
);

	// offered byte holds until transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pkt_byte) && $stable(end_of_packet))
		else $error("input byte changed while stalled");

	// stalled record holds until transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_type) &&
		$stable(option_kind) && $stable(mss_value) && $stable(tcp_window) &&
		$stable(last_of_run))
		else $error("output record changed while stalled");

	// option records carry a known version and no summary content
	a_opt_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_type == REC_OPTION |->
		(ip_version_code == 2'(ST_IPV4) || ip_version_code == 2'(ST_IPV6)) &&
		!last_of_run && hop_limit == 8'h00 && !mss_found && !wscale_found &&
		ip_ecn == 2'b00 && tcp_ecn == 2'b00)
		else $error("malformed option record");

	// invalid summary: last_of_run set, all data fields zero
	a_bad_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_type == REC_SUMMARY && ip_version_code == 2'(ST_UNKNOWN) |->
		last_of_run && option_kind == 8'h00 && hop_limit == 8'h00 &&
		tcp_window == 16'h0000 && !mss_found && !wscale_found &&
		ip_ecn == 2'b00 && tcp_ecn == 2'b00)
		else $error("invalid summary carries data");

	// values without their found flag read as zero
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mss_found || mss_value == 16'h0000) &&
		(wscale_found || wscale_value == 8'h00))
		else $error("option value present without found flag");

endmodule

bind syn_fingerprint_parser_top sfp_checker u_sfp_checker (.*);
